FILE: hdl/circular_interval_set_top_assert.svh
// Assertion macros for the circular interval set block.
`ifndef CIRCULAR_INTERVAL_SET_TOP_ASSERT_SVH
`define CIRCULAR_INTERVAL_SET_TOP_ASSERT_SVH
`ifndef SYNTH
`define CIS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CIS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define CIS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CIS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

FILE: hdl/cis_pkg.sv
// Shared constants and command types for the circular interval set block.
`default_nettype none
package cis_pkg;
    localparam int MAX_ARCS   = 16;
    localparam int ANGLE_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_ARCS);
    localparam int CNT_W      = $clog2(MAX_ARCS + 1);
    localparam int SPAN_W     = ANGLE_BITS + 1;
    localparam int TOT_W      = SPAN_W + CNT_W;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_CULL  = 3'd2;
    localparam logic [2:0] OP_POINT = 3'd3;
    localparam logic [2:0] OP_ARC   = 3'd4;
    localparam logic [2:0] OP_SAMP  = 3'd5;

    localparam logic CFG_PAD  = 1'b0;
    localparam logic CFG_CULL = 1'b1;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_INIT, CMD_WHOLE_SUB, CMD_WHOLE_CULL, CMD_CLR_POS,
        CMD_READ, CMD_SUB, CMD_CULL, CMD_TEST, CMD_SUM, CMD_POS, CMD_SCAN, CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic             whole;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] rd;
        logic             found;
        logic             hit;
    } t_status;
endpackage
`default_nettype wire

FILE: hdl/cis_ctrl.sv
// Controller sequencing the arc walks of each operation.
`default_nettype none
module cis_ctrl import cis_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire logic [2:0] i_op,
    input  wire t_status i_stat,
    input  wire logic    i_out_busy,
    output t_cmd         o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_WALK, S_POS, S_SCAN, S_DONE} t_state;
    t_state r_state, n_state;
    logic [2:0] r_op;

    assign o_ready = (r_state == S_IDLE) && !i_out_busy;

    always_comb begin
        n_state = r_state;
        o_cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) begin
                o_cmd = CMD_LOAD;
                n_state = S_WALK;
            end
            S_WALK: begin
                case (r_op) inside
                    OP_INIT: begin o_cmd = CMD_INIT; n_state = S_DONE; end
                    OP_SUB, OP_CULL: begin
                        if (i_stat.whole) begin
                            o_cmd = (r_op == OP_SUB) ? CMD_WHOLE_SUB : CMD_WHOLE_CULL;
                            n_state = S_DONE;
                        end else if (i_stat.rd >= i_stat.total) begin
                            n_state = S_DONE;
                        end else o_cmd = (r_op == OP_SUB) ? CMD_SUB : CMD_CULL;
                    end
                    OP_POINT, OP_ARC: begin
                        if (i_stat.whole || i_stat.hit || i_stat.rd >= i_stat.total)
                            n_state = S_DONE;
                        else o_cmd = CMD_TEST;
                    end
                    OP_SAMP: begin
                        if (i_stat.whole) n_state = S_DONE;
                        else if (i_stat.rd >= i_stat.total) n_state = S_POS;
                        else o_cmd = CMD_SUM;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_POS: begin o_cmd = CMD_POS; n_state = S_SCAN; end
            S_SCAN: begin
                if (i_stat.found || i_stat.rd >= i_stat.total) n_state = S_DONE;
                else o_cmd = CMD_SCAN;
            end
            S_DONE: begin o_cmd = CMD_FINISH; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_cmd == CMD_LOAD) r_op <= i_op;
    end
endmodule
`default_nettype wire

FILE: hdl/cis_dp.sv
// Datapath holding the arc table and per-arc arithmetic.
`default_nettype none
`include "circular_interval_set_top_assert.svh"
module cis_dp import cis_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [2:0]            i_op,
    input  wire logic [ANGLE_BITS-1:0] i_a,
    input  wire logic [15:0]           i_sp,
    input  wire logic [15:0]           i_frac,
    input  wire logic [15:0]           i_pad,
    input  wire logic [16:0]           i_cull,
    output t_status                    o_stat,
    output logic                       o_hit,
    output logic [ANGLE_BITS-1:0]      o_samp,
    output logic                       o_no_room,
    output logic                       o_ovf
);
    localparam logic [SPAN_W-1:0] CIRC = {1'b1, {ANGLE_BITS{1'b0}}};
    localparam logic [ANGLE_BITS-1:0] AZ = '0;

    logic [ANGLE_BITS-1:0] r_st [MAX_ARCS];
    logic [SPAN_W-1:0]     r_sn [MAX_ARCS];
    logic                  r_whole;
    logic [CNT_W-1:0]      r_total, r_rd, r_size;
    logic [ANGLE_BITS-1:0] r_a;
    logic [SPAN_W-1:0]     r_sp;
    logic [15:0]           r_frac;
    logic [2:0]            r_op;
    logic                  r_hit, r_found, r_ovf, r_no_room;
    logic [TOT_W-1:0]      r_sum, r_cur, r_pos;
    logic [ANGLE_BITS-1:0] r_samp;

    function automatic logic in_arc(input logic [ANGLE_BITS-1:0] s,
                                    input logic [SPAN_W-1:0] r,
                                    input logic [ANGLE_BITS-1:0] p);
        logic [ANGLE_BITS-1:0] d;
        d = p - s;
        return {1'b0, d} < r;
    endfunction

    logic [IDX_W-1:0] w_i;
    logic [ANGLE_BITS-1:0] w_s, w_ce, w_e, w_dlo, w_dhi;
    logic [SPAN_W-1:0] w_r, w_inc;
    logic w_meet, w_lo, w_hi, w_big;
    assign w_i   = r_rd[IDX_W-1:0];
    assign w_s   = r_st[w_i];
    assign w_r   = r_sn[w_i];
    assign w_ce  = r_a + r_sp[ANGLE_BITS-1:0];
    assign w_e   = w_s + w_r[ANGLE_BITS-1:0];
    assign w_lo  = in_arc(w_s, w_r, r_a);
    assign w_hi  = in_arc(w_s, w_r, w_ce);
    assign w_dlo = r_a - w_s;
    assign w_dhi = w_ce - w_s;
    assign w_meet = w_lo || w_hi || in_arc(r_a, r_sp, w_s) || in_arc(r_a, r_sp, w_e);
    assign w_big = w_r > {1'b0, i_pad};
    assign w_inc = w_r - {1'b0, i_pad};

    logic [16+TOT_W-1:0] w_prod;
    assign w_prod = {{TOT_W{1'b0}}, r_frac} * {16'd0, r_sum};

    logic [TOT_W-1:0] w_nc;
    assign w_nc = r_cur + {{CNT_W{1'b0}}, w_inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whole <= 1'b1;
            r_total <= CNT_W'(1);
        end else begin
            case (i_cmd)
                CMD_LOAD: begin
                    r_a <= i_a; r_sp <= {1'b0, i_sp}; r_frac <= i_frac; r_op <= i_op;
                    r_rd <= '0; r_size <= r_total; r_hit <= 1'b0; r_found <= 1'b0;
                    r_ovf <= 1'b0; r_no_room <= 1'b0; r_sum <= '0; r_cur <= '0;
                    r_samp <= '0;
                end
                CMD_INIT: begin r_whole <= 1'b1; r_total <= CNT_W'(1); end
                CMD_WHOLE_SUB: begin
                    r_whole <= 1'b0; r_total <= CNT_W'(1);
                    r_st[0] <= w_ce; r_sn[0] <= CIRC - r_sp;
                end
                CMD_WHOLE_CULL: if (CIRC < i_cull) begin
                    r_whole <= 1'b0; r_total <= '0;
                end
                CMD_SUB: begin
                    // r_rd walks original arcs; erased ones compact down
                    if (!w_meet) r_rd <= r_rd + CNT_W'(1);
                    else if (w_lo && w_hi && w_dlo < w_dhi) begin
                        r_sn[w_i] <= {1'b0, w_dlo};
                        if (r_total < CNT_W'(MAX_ARCS)) begin
                            r_st[r_total[IDX_W-1:0]] <= w_ce;
                            r_sn[r_total[IDX_W-1:0]] <= {1'b0, w_e - w_ce};
                            r_total <= r_total + CNT_W'(1);
                        end else r_ovf <= 1'b1;
                        r_rd <= r_rd + CNT_W'(1);
                    end else if (!w_lo && !w_hi) begin
                        for (int k = 0; k < MAX_ARCS - 1; k++)
                            if (CNT_W'(k) >= r_rd) begin
                                r_st[k] <= r_st[k+1]; r_sn[k] <= r_sn[k+1];
                            end
                        r_total <= r_total - CNT_W'(1);
                        r_size <= r_size - CNT_W'(1);
                    end else begin
                        if (w_hi) r_st[w_i] <= w_ce;
                        if (w_lo) r_sn[w_i] <= {1'b0, r_a - (w_hi ? w_ce : w_s)};
                        else r_sn[w_i] <= {1'b0, w_e - w_ce};
                        r_rd <= r_rd + CNT_W'(1);
                    end
                end
                CMD_CULL: begin
                    if (w_r < i_cull) begin
                        for (int k = 0; k < MAX_ARCS - 1; k++)
                            if (CNT_W'(k) >= r_rd) begin
                                r_st[k] <= r_st[k+1]; r_sn[k] <= r_sn[k+1];
                            end
                        r_total <= r_total - CNT_W'(1);
                    end else r_rd <= r_rd + CNT_W'(1);
                end
                CMD_TEST: begin
                    r_hit <= (r_op == OP_POINT) ? w_lo : w_meet;
                    r_rd <= r_rd + CNT_W'(1);
                end
                CMD_SUM: begin
                    if (w_big) r_sum <= r_sum + {{CNT_W{1'b0}}, w_inc};
                    r_rd <= r_rd + CNT_W'(1);
                end
                CMD_POS: begin r_pos <= TOT_W'(w_prod >> 16); r_rd <= '0; end
                CMD_SCAN: begin
                    if (w_big) begin
                        if (r_pos < w_nc) begin
                            r_found <= 1'b1;
                            r_samp <= w_s + {1'b0, i_pad[15:1]} +
                                ANGLE_BITS'(r_pos - r_cur);
                        end
                        r_cur <= w_nc;
                    end
                    r_rd <= r_rd + CNT_W'(1);
                end
                CMD_FINISH: begin
                    if (r_op == OP_POINT || r_op == OP_ARC) r_hit <= r_whole || r_hit;
                    if (r_op == OP_SAMP) begin
                        if (r_whole) r_samp <= ANGLE_BITS'(({16'd0, r_frac} << ANGLE_BITS)
                                                            >> 16);
                        else if (!r_found) begin r_no_room <= 1'b1; r_samp <= AZ; end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.whole = r_whole;
        o_stat.total = (r_op == OP_SUB) ? r_size : r_total;
        o_stat.count = r_total;
        o_stat.rd    = r_rd;
        o_stat.found = r_found;
        o_stat.hit   = r_hit;
    end
    assign o_hit = r_hit;
    assign o_samp = r_samp;
    assign o_no_room = r_no_room;
    assign o_ovf = r_ovf;

    `CIS_ASSERT_IMPL(a_total_max, i_clk, i_rst_n, r_total <= CNT_W'(MAX_ARCS), "arc count too big")
    `CIS_ASSERT_IMPL(a_whole_one, i_clk, i_rst_n, !r_whole || r_total == CNT_W'(1), "whole not one")
    `CIS_ASSERT_NEXT(a_init, i_clk, i_rst_n, i_cmd == CMD_INIT, r_whole, "init failed")
endmodule
`default_nettype wire

FILE: hdl/circular_interval_set_top.sv
// Top level of the circular interval set block.
// Usage:
//  - Input channel i_valid/o_ready carries one operation beat: opcode,
//    angle_start, angle_span and fraction. Output channel o_valid/i_ready
//    carries one result beat per operation.
//  - Configuration channel i_cfg_valid/o_cfg_ready writes sample_padding
//    (index 0) or cull_min_span (index 1); write only between operations.
//  - o_valid rises once the controller has walked the arcs held when the
//    input beat arrives (tests stop at the first hit). A sample walks the
//    table twice, summing and then scanning. Init, unknown opcodes and
//    whole-circle cases skip the walk. The per-arc sequencer over the arc
//    table sets this.
//  - Throughput: one operation in flight; o_ready returns the cycle after
//    the result beat is taken.
//  - Subtract and cull handle one arc a cycle and compact erased arcs in place.
//  - Reset makes the set the whole circle and zeroes both registers.
//  - While the receiver stalls, the result beat holds in the output
//    register and no new operation is taken.
`default_nettype none
module circular_interval_set_top import cis_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_angle_start,
    input  wire logic [15:0] i_angle_span,
    input  wire logic [15:0] i_fraction,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [15:0]      o_sample_angle,
    output logic             o_no_room,
    output logic             o_overflow,
    output logic             o_set_empty,
    output logic [4:0]       o_arc_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    logic [15:0] r_pad;
    logic [16:0] r_cull;
    t_cmd w_cmd;
    t_status w_stat;
    logic w_hit, w_nr, w_ovf;
    logic [ANGLE_BITS-1:0] w_samp;
    logic [2:0] r_op;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= '0; r_cull <= '0;
        end else if (i_cfg_valid) begin
            // hold registers unless index matches
            if (i_cfg_index == CFG_PAD) r_pad <= i_cfg_data[15:0];
            else if (i_cfg_index == CFG_CULL) r_cull <= i_cfg_data;
        end
    end

    cis_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_op(i_opcode),
        .i_stat(w_stat), .i_out_busy(o_valid), .o_cmd(w_cmd)
    );

    cis_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_op(i_opcode), .i_a(i_angle_start),
        .i_sp(i_angle_span), .i_frac(i_fraction), .i_pad(r_pad), .i_cull(r_cull),
        .o_stat(w_stat), .o_hit(w_hit), .o_samp(w_samp), .o_no_room(w_nr), .o_ovf(w_ovf)
    );

    // Raise valid on the edge that commits the result; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            if (w_cmd == CMD_FINISH) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
        if (w_cmd == CMD_LOAD) r_op <= i_opcode;
    end

    assign o_hit = (r_op == OP_POINT || r_op == OP_ARC) ? w_hit : 1'b0;
    assign o_sample_angle = (r_op == OP_SAMP) ? w_samp : 16'd0;
    assign o_no_room = (r_op == OP_SAMP) ? w_nr : 1'b0;
    assign o_overflow = (r_op == OP_SUB) ? w_ovf : 1'b0;
    // the whole circle is held as one arc, so the count alone decides emptiness
    assign o_set_empty = (w_stat.count == '0);
    assign o_arc_count = w_stat.count;
endmodule
`default_nettype wire
